### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define BBVP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbvp: same-cycle check failed");

// next-cycle implication check
`define BBVP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbvp: next-cycle check failed");

`endif

### design/bbvp_pkg.sv
package bbvp_pkg;

  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] REG_VLIM = 2'd0;
  localparam logic [1:0] REG_ALIM = 2'd1;
  localparam logic [1:0] REG_TOL  = 2'd2;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [32:0] d;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [32:0] dv;
    logic               dvzero;
    logic               is_null;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] accel;
    logic [30:0]        dur;
    logic signed [31:0] pos;
    logic               last;
  } ramp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef enum logic [1:0] {
    MODE_NULL,
    MODE_STRAIGHT,
    MODE_TWO,
    MODE_THREE
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_CLS,
    ST_DSW,
    ST_DIFF,
    ST_SG,
    ST_CMP,
    ST_SQW,
    ST_D2W,
    ST_TNUM,
    ST_TW,
    ST_EMIT
  } state_e;

endpackage

### design/bang_bang_velocity_profile_1d.sv
// Channel   Handshake             Payload
// move in   push / full           start_pos_i end_pos_i start_vel_i end_vel_i
// ramp out  empty / pop           ramp_vel_o ramp_accel_o ramp_time_o ramp_pos_o ramp_last_o
// config    cfg_valid_i / ready   cfg_index_i cfg_data_i
//
// A move starts with squares and one product on the shared multiplier, then
// the shared one-bit-per-cycle divider for the straight distance, the cruise
// distance and every ramp of positive duration, or the root for the peak speed.
// Reset is asynchronous; full is low out of reset, so the block can take a move once it ends. Up to two moves
// wait ahead of the sequencer and up to four ramps wait for pop, so each side stalls alone.
`include "assert_macros.svh"

module bang_bang_velocity_profile_1d #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_pos_i,
  input  logic signed [31:0] end_pos_i,
  input  logic signed [31:0] start_vel_i,
  input  logic signed [31:0] end_vel_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] ramp_vel_o,
  output logic signed [31:0] ramp_accel_o,
  output logic [30:0]        ramp_time_o,
  output logic signed [31:0] ramp_pos_o,
  output logic               ramp_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);
  import bbvp_pkg::*;

  localparam logic [30:0] VLIM_RST = 31'(64'd1 << FRAC_BITS);
  localparam logic [16:0] TOL_RST  = 17'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  logic [30:0] vlim_q, alim_q;
  logic [16:0] tol_q;
  item_t       itm;
  logic        itm_valid, itm_ready;
  ramp_t       rmp;
  logic        cruise;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q <= VLIM_RST;
      alim_q <= VLIM_RST;
      tol_q  <= TOL_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_VLIM) vlim_q <= cfg_data_i;
      if (cfg_index_i == REG_ALIM) alim_q <= cfg_data_i;
      if (cfg_index_i == REG_TOL) tol_q <= cfg_data_i[16:0];
    end
  end

  bbvp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .start_pos_i  (start_pos_i),
    .end_pos_i    (end_pos_i),
    .start_vel_i  (start_vel_i),
    .end_vel_i    (end_vel_i),
    .vlim_i       (vlim_q),
    .tol_i        (tol_q),
    .item_o       (itm),
    .item_valid_o (itm_valid),
    .item_ready_i (itm_ready)
  );

  bbvp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (itm),
    .item_valid_i (itm_valid),
    .item_ready_o (itm_ready),
    .vlim_i       (vlim_q),
    .alim_i       (alim_q),
    .tol_i        (tol_q),
    .ramp_o       (rmp),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  assign ramp_vel_o   = rmp.vel;
  assign ramp_accel_o = rmp.accel;
  assign ramp_time_o  = rmp.dur;
  assign ramp_pos_o   = rmp.pos;
  assign ramp_last_o  = rmp.last;

  assign cruise = !empty && !ramp_last_o && (ramp_accel_o == 32'sd0);

  `BBVP_ASSERT_NXT(a_push_lands, push && !full, itm_valid)
  `BBVP_ASSERT_IMP(a_full_has_item, full, itm_valid)
  `BBVP_ASSERT_IMP(a_cruise_moves, cruise, ramp_vel_o != 32'sd0)

endmodule

### design/bbvp_front.sv
module bbvp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [31:0] start_pos_i,
  input  logic signed [31:0] end_pos_i,
  input  logic signed [31:0] start_vel_i,
  input  logic signed [31:0] end_vel_i,
  input  logic [30:0]        vlim_i,
  input  logic [16:0]        tol_i,
  output bbvp_pkg::item_t    item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);
  import bbvp_pkg::*;

  function automatic logic signed [31:0] sat_vel(input logic signed [31:0] v,
                                                 input logic [30:0] m);
    logic signed [32:0] ve;
    logic signed [32:0] me;
    logic signed [31:0] r;
    ve = 33'(v);
    me = $signed({2'b00, m});
    if (ve > me) begin
      r = me[31:0];
    end else if (ve < -me) begin
      r = 32'(-me);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [30:0]        vm;
  logic signed [31:0] v0s, v1s;
  logic signed [32:0] d, dv;
  logic [32:0]        dmag, dvmag;
  item_t              itm;
  logic               push_ok, pop_ok;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign vm    = (vlim_i == 31'd0) ? 31'd1 : vlim_i;
  assign v0s   = sat_vel(start_vel_i, vm);
  assign v1s   = sat_vel(end_vel_i, vm);
  assign d     = 33'(end_pos_i) - 33'(start_pos_i);
  assign dv    = 33'(v1s) - 33'(v0s);
  assign dmag  = d[32] ? 33'(-d) : 33'(d);
  assign dvmag = dv[32] ? 33'(-dv) : 33'(dv);

  always_comb begin
    itm.x0      = start_pos_i;
    itm.d       = d;
    itm.v0      = v0s;
    itm.v1      = v1s;
    itm.dv      = dv;
    itm.dvzero  = dvmag < {16'd0, tol_i};
    itm.is_null = itm.dvzero && (dmag < {16'd0, tol_i});
  end

  assign full_o       = cnt_q == 2'd2;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = mem_q[rp_q];
  assign push_ok      = push_i && !full_o;
  assign pop_ok       = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wp_q] <= itm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) wp_q <= ~wp_q;
      if (pop_ok) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule

### design/bbvp_div.sv
module bbvp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbvp_pkg::div_req_t  req_i,
  output bbvp_pkg::div_rsp_t  rsp_o
);
  import bbvp_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q, quo_q;
  logic [32:0] den_q, rem_q;
  logic [33:0] rem_n;
  logic        ge;

  assign rem_n = {rem_q, num_q[63]};
  assign ge    = rem_n >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= ge ? 33'(rem_n - {1'b0, den_q}) : rem_n[32:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### design/bbvp_sqrt.sv
module bbvp_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbvp_pkg::sqrt_req_t  req_i,
  output bbvp_pkg::sqrt_rsp_t  rsp_o
);
  import bbvp_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_n, trial;
  logic        ge;

  assign rem_n = {rem_q, x_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_n >= trial;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(rem_n - trial) : rem_n[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

### design/bbvp_back.sv
module bbvp_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbvp_pkg::item_t  item_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  logic [30:0]      vlim_i,
  input  logic [30:0]      alim_i,
  input  logic [16:0]      tol_i,
  output bbvp_pkg::ramp_t  ramp_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import bbvp_pkg::*;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  state_e state_q, state_d;
  mode_e  mode_q;
  logic [1:0] r_q;

  item_t              it_q;
  logic [31:0]        mul_a_q, mul_b_q;
  logic [63:0]        prod_q;
  logic [63:0]        sq0_q, sq1_q, vm2_q, pr_q, rad_q;
  logic signed [63:0] ds_q, diff_q, nc_q;
  logic signed [33:0] sd_q;
  logic               sg_q;
  logic [31:0]        vp_q;
  logic [30:0]        dur_q;

  logic [30:0]        vmu, amu;
  logic [63:0]        sum, half, dsmag, d2num, absdiff, rad_c;
  logic [64:0]        radsum;
  logic               dsneg, sg_c, straight;
  logic signed [33:0] sd_c;
  logic signed [63:0] v0e, v1e, sgv0, sgv1, vpe, vme, tnum;
  logic signed [31:0] ams, vms, vps;
  logic [32:0]        tden;
  logic               opush, ofull;
  ramp_t              rmp;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  sqrt_req_t          sq_req;
  sqrt_rsp_t          sq_rsp;
  logic [30:0]        dur_sat;

  ramp_t      oq_q [4];
  logic [1:0] owp_q, orp_q;
  logic [2:0] ocnt_q;

  bbvp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bbvp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  assign vmu     = (vlim_i == 31'd0) ? 31'd1 : vlim_i;
  assign amu     = (alim_i == 31'd0) ? 31'd1 : alim_i;
  assign sum     = sq0_q + sq1_q;
  assign half    = {1'b0, sum[63:1]};
  assign dsmag   = (sq1_q >= sq0_q) ? sq1_q - sq0_q : sq0_q - sq1_q;
  assign dsneg   = (sq1_q < sq0_q) ^ it_q.dv[32];
  assign d2num   = {vm2_q[62:0], 1'b0} - sum;
  assign absdiff = diff_q[63] ? 64'(-diff_q) : 64'(diff_q);
  assign straight = absdiff <= {47'd0, tol_i};
  assign sg_c    = !diff_q[63];
  assign sd_c    = sg_c ? 34'(it_q.d) : -34'(it_q.d);
  assign radsum  = {1'b0, half} + {1'b0, pr_q};

  always_comb begin
    if (!sd_c[33]) begin
      rad_c = radsum[64] ? '1 : radsum[63:0];
    end else begin
      rad_c = (pr_q >= half) ? 64'd0 : half - pr_q;
    end
  end

  assign v0e  = 64'(it_q.v0);
  assign v1e  = 64'(it_q.v1);
  assign sgv0 = sg_q ? v0e : -v0e;
  assign sgv1 = sg_q ? v1e : -v1e;
  assign vpe  = $signed({32'd0, vp_q});
  assign vme  = $signed({33'd0, vmu});
  assign ams  = $signed({1'b0, amu});
  assign vms  = $signed({1'b0, vmu});
  assign vps  = sg_q ? $signed(vp_q) : -$signed(vp_q);

  always_comb begin
    rmp.vel   = it_q.v0;
    rmp.accel = sg_q ? ams : -ams;
    rmp.dur   = dur_q;
    rmp.pos   = (r_q == 2'd0) ? it_q.x0 : 32'sd0;
    rmp.last  = 1'b1;
    tnum      = 64'sd0;
    tden      = {2'b00, amu};
    unique case (mode_q)
      MODE_NULL: begin
        rmp.vel   = 32'sd0;
        rmp.accel = 32'sd0;
      end
      MODE_STRAIGHT: begin
        if (it_q.dv[32]) begin
          rmp.accel = -ams;
          tnum      = -64'(it_q.dv);
        end else if (it_q.dv != 33'sd0) begin
          rmp.accel = ams;
          tnum      = 64'(it_q.dv);
        end else begin
          rmp.accel = 32'sd0;
        end
      end
      MODE_TWO: begin
        if (r_q == 2'd0) begin
          rmp.last = 1'b0;
          tnum     = vpe - sgv0;
        end else begin
          rmp.vel   = vps;
          rmp.accel = sg_q ? -ams : ams;
          tnum      = vpe - sgv1;
        end
      end
      MODE_THREE: begin
        if (r_q == 2'd0) begin
          rmp.last = 1'b0;
          tnum     = vme - sgv0;
        end else if (r_q == 2'd1) begin
          rmp.last  = 1'b0;
          rmp.vel   = sg_q ? vms : -vms;
          rmp.accel = 32'sd0;
          tnum      = nc_q;
          tden      = {2'b00, vmu};
        end else begin
          rmp.vel   = sg_q ? vms : -vms;
          rmp.accel = sg_q ? -ams : ams;
          tnum      = vme - sgv1;
        end
      end
      default: ;
    endcase
  end

  assign dur_sat = (div_rsp.quo > {33'd0, TIME_MAX}) ? TIME_MAX : div_rsp.quo[30:0];
  assign ofull   = ocnt_q == 3'd4;

  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    div_req      = '0;
    sq_req       = '0;
    opush        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) state_d = ST_M1;
      end
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_M3;
      ST_M3: state_d = ST_M4;
      ST_M4: state_d = ST_M5;
      ST_M5: state_d = ST_CLS;
      ST_CLS: begin
        if (it_q.is_null) begin
          state_d = ST_TNUM;
        end else if (it_q.dvzero) begin
          state_d = ST_DIFF;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = dsmag;
          div_req.den   = {1'b0, amu, 1'b0};
          state_d       = ST_DSW;
        end
      end
      ST_DSW: if (div_rsp.done) state_d = ST_DIFF;
      ST_DIFF: state_d = ST_SG;
      ST_SG: state_d = straight ? ST_TNUM : ST_CMP;
      ST_CMP: begin
        if (rad_q < vm2_q) begin
          sq_req.start = 1'b1;
          sq_req.rad   = rad_q;
          state_d      = ST_SQW;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = d2num;
          div_req.den   = {1'b0, amu, 1'b0};
          state_d       = ST_D2W;
        end
      end
      ST_SQW: if (sq_rsp.done) state_d = ST_TNUM;
      ST_D2W: if (div_rsp.done) state_d = ST_TNUM;
      ST_TNUM: begin
        if (tnum <= 64'sd0) begin
          state_d = ST_EMIT;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = $unsigned(tnum) << FRAC_BITS;
          div_req.den   = tden;
          state_d       = ST_TW;
        end
      end
      ST_TW: if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!ofull) begin
          opush   = 1'b1;
          state_d = rmp.last ? ST_IDLE : ST_TNUM;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
    unique case (state_q)
      ST_IDLE: begin
        it_q    <= item_i;
        mul_a_q <= mag32(item_i.v0);
        mul_b_q <= mag32(item_i.v0);
      end
      ST_M1: begin
        mul_a_q <= mag32(it_q.v1);
        mul_b_q <= mag32(it_q.v1);
      end
      ST_M2: begin
        sq0_q   <= prod_q;
        mul_a_q <= {1'b0, vmu};
        mul_b_q <= {1'b0, vmu};
      end
      ST_M3: begin
        sq1_q   <= prod_q;
        mul_a_q <= {1'b0, amu};
        mul_b_q <= it_q.d[32] ? 32'(-it_q.d) : 32'(it_q.d);
      end
      ST_M4: vm2_q <= prod_q;
      ST_M5: pr_q <= prod_q;
      ST_CLS: begin
        ds_q   <= 64'sd0;
        r_q    <= 2'd0;
        mode_q <= MODE_NULL;
        sg_q   <= 1'b1;
        dur_q  <= '0;
      end
      ST_DSW: if (div_rsp.done) ds_q <= dsneg ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
      ST_DIFF: diff_q <= 64'(it_q.d) - ds_q;
      ST_SG: begin
        sg_q  <= sg_c;
        sd_q  <= sd_c;
        rad_q <= rad_c;
        if (straight) mode_q <= MODE_STRAIGHT;
      end
      ST_SQW: begin
        if (sq_rsp.done) begin
          vp_q   <= sq_rsp.root;
          mode_q <= MODE_TWO;
        end
      end
      ST_D2W: begin
        if (div_rsp.done) begin
          nc_q   <= 64'(sd_q) - $signed(div_rsp.quo);
          mode_q <= MODE_THREE;
        end
      end
      ST_TNUM: if (tnum <= 64'sd0) dur_q <= '0;
      ST_TW: if (div_rsp.done) dur_q <= dur_sat;
      ST_EMIT: if (!ofull) r_q <= r_q + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owp_q] <= rmp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) owp_q <= owp_q + 2'd1;
      if (pop_i && !empty_o) orp_q <= orp_q + 2'd1;
      ocnt_q <= ocnt_q + 3'(opush) - 3'(pop_i && !empty_o);
    end
  end

  assign empty_o = ocnt_q == 3'd0;
  assign ramp_o  = oq_q[orp_q];

endmodule
